FILE: rtl/core/skf_pkg.sv
// skf_pkg: shared types, constants and fixed-point helpers for the scalar Kalman filter.
// Depends on nothing; used by skf_datapath, skf_ctrl and scalar_kalman_filter.
package skf_pkg;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int PW = 2 * DW;

    typedef logic signed [DW-1:0] word_t;
    typedef logic signed [PW-1:0] prod_t;

    localparam word_t WMAX = {1'b0, {(DW-1){1'b1}}};
    localparam word_t WMIN = {1'b1, {(DW-1){1'b0}}};
    localparam word_t ONE  = word_t'(64'sd1 <<< FB);

    typedef enum logic [2:0] {
        REG_A  = 3'd0,
        REG_B  = 3'd1,
        REG_Q  = 3'd2,
        REG_C  = 3'd3,
        REG_R  = 3'd4,
        REG_X0 = 3'd5,
        REG_P0 = 3'd6
    } reg_idx_t;

    // datapath operations, one per controller step
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,    // latch inputs, restart reload
        OP_AX,      // t0 = a*x
        OP_BU,      // t1 = b*u
        OP_XP,      // xp = t0 + t1
        OP_AA,      // t0 = a*a
        OP_AAP,     // t0 = t0*p
        OP_BB,      // t1 = b*b
        OP_BBQ,     // t1 = t1*q
        OP_PP,      // pp = t0 + t1
        OP_CP,      // cp = c*pp
        OP_CCP,     // t0 = c*cp
        OP_DEN,     // den = t0 + r
        OP_DIVST,   // start divider
        OP_DIVSTEP, // one quotient bit
        OP_DIVEND,  // g from quotient
        OP_CXP,     // t0 = c*xp
        OP_INN,     // t0 = y - t0
        OP_GI,      // t0 = g*t0
        OP_XN,      // xn = xp + t0
        OP_GC,      // t0 = g*c
        OP_OMG,     // t0 = 1 - t0
        OP_PN,      // pn = t0*pp
        OP_CXN,     // t0 = c*xn
        OP_RES      // res = y - t0, commit state
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        word_t v;
        logic  sat;
    } sres_t;

    // product shifted right by FB with floor rounding, saturated
    function automatic sres_t fmul(word_t x, word_t y);
        prod_t p;
        prod_t s;
        sres_t r;
        begin
            p = prod_t'(x) * prod_t'(y);
            s = p >>> FB;
            if (s > prod_t'(WMAX)) begin
                r.v = WMAX; r.sat = 1'b1;
            end else if (s < prod_t'(WMIN)) begin
                r.v = WMIN; r.sat = 1'b1;
            end else begin
                r.v = s[DW-1:0]; r.sat = 1'b0;
            end
            return r;
        end
    endfunction

    function automatic sres_t sat_add(word_t x, word_t y, logic sub);
        logic signed [DW:0] s;
        sres_t r;
        begin
            s = sub ? ({x[DW-1], x} - {y[DW-1], y}) : ({x[DW-1], x} + {y[DW-1], y});
            if (s[DW] != s[DW-1]) begin
                r.v = s[DW] ? WMIN : WMAX; r.sat = 1'b1;
            end else begin
                r.v = s[DW-1:0]; r.sat = 1'b0;
            end
            return r;
        end
    endfunction

endpackage

FILE: rtl/core/scalar_kalman_filter.sv
// scalar_kalman_filter: top level of the one-dimensional Kalman filter.
// Depends on skf_pkg, skf_ctrl and skf_datapath.
//
// Usage:
//   Input channel s_*: control input u, observation y and a restart flag per
//   transfer. Each transfer runs one predict/correct step in Q16.16.
//   Result channel m_*: posterior estimate, variance, gain, residual (y - c*x+)
//   and a fault flag (saturation, non-positive denominator, negative variance).
//   Configuration channel cfg_*: write register cfg_index with cfg_data while
//   the block is idle; indexes beyond six are ignored.
//   Sequence: the inputs are latched on the transfer edge, then 22 sequencer
//   steps run on one shared multiplier/adder plus a 48-step restoring divider,
//   one quotient bit per cycle. One item is in flight at a time, so a new
//   input is taken only after the previous result has been accepted.
//   Stall: the result is held until m_ready; no new input is taken meanwhile.
//   Reset: the configuration registers return to their defaults and the state
//   is loaded with the default initial estimate and variance.
module scalar_kalman_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_control_input,
    input  logic [31:0] s_observation,
    input  logic        s_restart,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_posterior_estimate,
    output logic [30:0] m_posterior_variance,
    output logic [31:0] m_kalman_gain,
    output logic [31:0] m_residual,
    output logic        m_fault,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    skf_pkg::word_t a_reg, b_reg, q_reg, c_reg, r_reg, x0_reg, p0_reg;
    skf_pkg::cmd_t  cmd;
    skf_pkg::stat_t stat;
    skf_pkg::word_t xn, pn, gain, res;
    logic           fault;

    assign cfg_ready = 1'b1;

    // configuration registers; variances take the low 31 bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg <= skf_pkg::ONE; b_reg <= '0; q_reg <= skf_pkg::ONE;
            c_reg <= skf_pkg::ONE; r_reg <= skf_pkg::ONE; x0_reg <= '0;
            p0_reg <= skf_pkg::ONE;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                skf_pkg::REG_A:  a_reg  <= cfg_data;
                skf_pkg::REG_B:  b_reg  <= cfg_data;
                skf_pkg::REG_Q:  q_reg  <= {1'b0, cfg_data[30:0]};
                skf_pkg::REG_C:  c_reg  <= cfg_data;
                skf_pkg::REG_R:  r_reg  <= {1'b0, cfg_data[30:0]};
                skf_pkg::REG_X0: x0_reg <= cfg_data;
                skf_pkg::REG_P0: p0_reg <= {1'b0, cfg_data[30:0]};
                default: ;
            endcase
        end
    end

    skf_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd), .stat(stat)
    );

    skf_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .cfg_a(a_reg), .cfg_b(b_reg), .cfg_q(q_reg), .cfg_c(c_reg), .cfg_r(r_reg),
        .cfg_x0(x0_reg), .cfg_p0(p0_reg),
        .in_u(s_control_input), .in_y(s_observation), .in_restart(s_restart),
        .xn(xn), .pn(pn), .gain(gain), .res(res), .fault(fault)
    );

    assign m_posterior_estimate = xn;
    assign m_posterior_variance = pn[30:0];
    assign m_kalman_gain        = gain;
    assign m_residual           = res;
    assign m_fault              = fault;

endmodule

FILE: rtl/core/skf_datapath.sv
// skf_datapath: operand registers, one shared multiplier, saturating adder and
// a restoring divider. Depends on skf_pkg; driven by skf_ctrl.
module skf_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  skf_pkg::cmd_t        cmd,
    output skf_pkg::stat_t       stat,
    input  skf_pkg::word_t       cfg_a,
    input  skf_pkg::word_t       cfg_b,
    input  skf_pkg::word_t       cfg_q,
    input  skf_pkg::word_t       cfg_c,
    input  skf_pkg::word_t       cfg_r,
    input  skf_pkg::word_t       cfg_x0,
    input  skf_pkg::word_t       cfg_p0,
    input  skf_pkg::word_t       in_u,
    input  skf_pkg::word_t       in_y,
    input  logic                 in_restart,
    output skf_pkg::word_t       xn,
    output skf_pkg::word_t       pn,
    output skf_pkg::word_t       gain,
    output skf_pkg::word_t       res,
    output logic                 fault
);

    localparam int QW = skf_pkg::DW + skf_pkg::FB;
    localparam int CW = $clog2(QW + 1);

    skf_pkg::word_t x_reg, x_next, p_reg, p_next;
    skf_pkg::word_t u_reg, y_reg, t0_reg, t0_next, t1_reg, t1_next;
    skf_pkg::word_t xp_reg, xp_next, pp_reg, pp_next, cp_reg, cp_next;
    skf_pkg::word_t den_reg, den_next, g_reg, g_next, xn_reg, xn_next, res_reg, res_next;
    logic           flt_reg, flt_next, neg_reg, neg_next, dz_reg, dz_next;
    logic [QW-1:0]  num_reg, num_next;
    logic [skf_pkg::DW:0] rem_reg, rem_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    skf_pkg::word_t ma, mb;
    skf_pkg::sres_t mr, ar;
    logic [skf_pkg::DW:0] rsh;
    logic [skf_pkg::DW:0] cmag;
    logic [QW-1:0]  qmax;

    // operand selection for the shared multiplier and adder
    always_comb begin
        ma = t0_reg; mb = t0_reg;
        unique case (cmd.op)
            skf_pkg::OP_AX:  begin ma = cfg_a; mb = x_reg; end
            skf_pkg::OP_BU:  begin ma = cfg_b; mb = u_reg; end
            skf_pkg::OP_AA:  begin ma = cfg_a; mb = cfg_a; end
            skf_pkg::OP_AAP: begin ma = t0_reg; mb = p_reg; end
            skf_pkg::OP_BB:  begin ma = cfg_b; mb = cfg_b; end
            skf_pkg::OP_BBQ: begin ma = t1_reg; mb = cfg_q; end
            skf_pkg::OP_CP:  begin ma = cfg_c; mb = pp_reg; end
            skf_pkg::OP_CCP: begin ma = cfg_c; mb = cp_reg; end
            skf_pkg::OP_CXP: begin ma = cfg_c; mb = xp_reg; end
            skf_pkg::OP_GI:  begin ma = g_reg; mb = t0_reg; end
            skf_pkg::OP_GC:  begin ma = g_reg; mb = cfg_c; end
            skf_pkg::OP_PN:  begin ma = t0_reg; mb = pp_reg; end
            skf_pkg::OP_CXN: begin ma = cfg_c; mb = xn_reg; end
            default: ;
        endcase
        mr = skf_pkg::fmul(ma, mb);
        unique case (cmd.op)
            skf_pkg::OP_XP:  ar = skf_pkg::sat_add(t0_reg, t1_reg, 1'b0);
            skf_pkg::OP_PP:  ar = skf_pkg::sat_add(t0_reg, t1_reg, 1'b0);
            skf_pkg::OP_DEN: ar = skf_pkg::sat_add(t0_reg, cfg_r, 1'b0);
            skf_pkg::OP_INN: ar = skf_pkg::sat_add(y_reg, t0_reg, 1'b1);
            skf_pkg::OP_XN:  ar = skf_pkg::sat_add(xp_reg, t0_reg, 1'b0);
            skf_pkg::OP_OMG: ar = skf_pkg::sat_add(skf_pkg::ONE, t0_reg, 1'b1);
            skf_pkg::OP_RES: ar = skf_pkg::sat_add(y_reg, t0_reg, 1'b1);
            default:         ar = skf_pkg::sat_add(t0_reg, t1_reg, 1'b0);
        endcase
    end

    assign cmag = cp_reg[skf_pkg::DW-1] ? ({1'b0, ~cp_reg} + 1'b1) : {1'b0, cp_reg};
    assign rsh  = {rem_reg[skf_pkg::DW-1:0], num_reg[QW-1]};
    // largest quotient magnitude that fits the sign of the result
    assign qmax = neg_reg ? QW'({1'b1, {(skf_pkg::DW-1){1'b0}}})
                          : QW'({1'b0, {(skf_pkg::DW-1){1'b1}}});

    always_comb begin
        x_next = x_reg; p_next = p_reg; t0_next = t0_reg; t1_next = t1_reg;
        xp_next = xp_reg; pp_next = pp_reg; cp_next = cp_reg; den_next = den_reg;
        g_next = g_reg; xn_next = xn_reg; res_next = res_reg; flt_next = flt_reg;
        neg_next = neg_reg; dz_next = dz_reg; num_next = num_reg; rem_next = rem_reg;
        cnt_next = cnt_reg;
        unique case (cmd.op)
            skf_pkg::OP_LOAD: begin
                if (in_restart) begin
                    x_next = cfg_x0; p_next = cfg_p0;
                end
                flt_next = 1'b0;
            end
            skf_pkg::OP_AX, skf_pkg::OP_AA, skf_pkg::OP_AAP, skf_pkg::OP_CCP,
            skf_pkg::OP_CXP, skf_pkg::OP_GI, skf_pkg::OP_GC, skf_pkg::OP_CXN: begin
                t0_next = mr.v; flt_next = flt_reg | mr.sat;
            end
            skf_pkg::OP_BU, skf_pkg::OP_BB, skf_pkg::OP_BBQ: begin
                t1_next = mr.v; flt_next = flt_reg | mr.sat;
            end
            skf_pkg::OP_CP: begin
                cp_next = mr.v; flt_next = flt_reg | mr.sat;
            end
            skf_pkg::OP_PN: begin
                if (mr.v[skf_pkg::DW-1]) begin
                    p_next = '0; flt_next = 1'b1;
                end else begin
                    p_next = mr.v; flt_next = flt_reg | mr.sat;
                end
            end
            skf_pkg::OP_XP:  begin xp_next = ar.v; flt_next = flt_reg | ar.sat; end
            skf_pkg::OP_PP:  begin pp_next = ar.v; flt_next = flt_reg | ar.sat; end
            skf_pkg::OP_DEN: begin den_next = ar.v; flt_next = flt_reg | ar.sat; end
            skf_pkg::OP_INN, skf_pkg::OP_OMG: begin
                t0_next = ar.v; flt_next = flt_reg | ar.sat;
            end
            skf_pkg::OP_XN:  begin xn_next = ar.v; flt_next = flt_reg | ar.sat; end
            skf_pkg::OP_RES: begin
                res_next = ar.v; flt_next = flt_reg | ar.sat; x_next = xn_reg;
            end
            skf_pkg::OP_DIVST: begin
                dz_next  = den_reg[skf_pkg::DW-1] || (den_reg == '0);
                neg_next = cp_reg[skf_pkg::DW-1];
                num_next = {cmag[skf_pkg::DW-1:0], {skf_pkg::FB{1'b0}}};
                rem_next = '0;
                cnt_next = CW'(QW);
            end
            skf_pkg::OP_DIVSTEP: begin
                // one restoring step: shift in the next dividend bit
                num_next = {num_reg[QW-2:0], 1'b0};
                if (rsh >= {1'b0, den_reg}) begin
                    rem_next = rsh - {1'b0, den_reg};
                    num_next[0] = 1'b1;
                end else begin
                    rem_next = rsh;
                end
                cnt_next = cnt_reg - 1'b1;
            end
            skf_pkg::OP_DIVEND: begin
                if (dz_reg) begin
                    g_next = '0; flt_next = 1'b1;
                end else if (num_reg > qmax) begin
                    g_next = neg_reg ? skf_pkg::WMIN : skf_pkg::WMAX;
                    flt_next = 1'b1;
                end else begin
                    g_next = neg_reg ? -num_reg[skf_pkg::DW-1:0] : num_reg[skf_pkg::DW-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg <= '0;
            p_reg <= skf_pkg::ONE;
            flt_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            x_reg <= x_next; p_reg <= p_next; flt_reg <= flt_next; cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == skf_pkg::OP_LOAD) begin
            u_reg <= in_u; y_reg <= in_y;
        end
        t0_reg <= t0_next; t1_reg <= t1_next; xp_reg <= xp_next; pp_reg <= pp_next;
        cp_reg <= cp_next; den_reg <= den_next; g_reg <= g_next; xn_reg <= xn_next;
        res_reg <= res_next; neg_reg <= neg_next; dz_reg <= dz_next;
        num_reg <= num_next; rem_reg <= rem_next;
    end

    assign stat.div_done = (cnt_reg == CW'(1));
    assign xn    = xn_reg;
    assign pn    = p_reg;
    assign gain  = g_reg;
    assign res   = res_reg;
    assign fault = flt_reg;

endmodule

FILE: rtl/core/skf_ctrl.sv
// skf_ctrl: sequencer that steps the datapath through one filter update.
// Depends on skf_pkg; drives skf_datapath.
module skf_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    output skf_pkg::cmd_t   cmd,
    input  skf_pkg::stat_t  stat
);

    skf_pkg::state_t state_reg, state_next;
    skf_pkg::op_t    op_reg, op_next;

    always_comb begin
        state_next = state_reg;
        op_next = op_reg;
        unique case (state_reg)
            skf_pkg::ST_IDLE: if (s_valid) begin
                state_next = skf_pkg::ST_RUN; op_next = skf_pkg::OP_AX;
            end
            skf_pkg::ST_RUN: begin
                if (op_reg == skf_pkg::OP_DIVST) begin
                    state_next = skf_pkg::ST_DIV; op_next = skf_pkg::OP_DIVSTEP;
                end else if (op_reg == skf_pkg::OP_RES) begin
                    state_next = skf_pkg::ST_OUT; op_next = skf_pkg::OP_NONE;
                end else begin
                    op_next = skf_pkg::op_t'(op_reg + 1'b1);
                end
            end
            skf_pkg::ST_DIV: if (stat.div_done) begin
                state_next = skf_pkg::ST_RUN; op_next = skf_pkg::OP_DIVEND;
            end
            skf_pkg::ST_OUT: if (m_ready) begin
                state_next = skf_pkg::ST_IDLE;
            end
            default: state_next = skf_pkg::ST_IDLE;
        endcase
    end

    // latch the input on the transfer edge itself
    always_comb begin
        s_ready = (state_reg == skf_pkg::ST_IDLE);
        m_valid = (state_reg == skf_pkg::ST_OUT);
        unique case (state_reg)
            skf_pkg::ST_IDLE: cmd.op = s_valid ? skf_pkg::OP_LOAD : skf_pkg::OP_NONE;
            skf_pkg::ST_OUT:  cmd.op = skf_pkg::OP_NONE;
            default:          cmd.op = op_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= skf_pkg::ST_IDLE;
            op_reg <= skf_pkg::OP_NONE;
        end else begin
            state_reg <= state_next;
            op_reg <= (state_reg == skf_pkg::ST_IDLE && !s_valid) ? skf_pkg::OP_NONE
                                                                    : op_next;
        end
    end

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready and valid both high");
    a_res_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (op_reg == skf_pkg::OP_RES && state_reg == skf_pkg::ST_RUN) |=> m_valid)
        else $error("result not presented");
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");

endmodule
